@@ rtl/core/suv_pkg.sv @@
// Package for the segment unit vector block: widths, pipeline structs and
// the single root-digit step shared by both component lanes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package suv_pkg;

  localparam int COORD_BITS     = 24;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int UNIT_W         = 16;

  localparam int DIFF_W = COORD_BITS + 1;            // difference, never wraps
  localparam int MAG_W  = COORD_BITS;                // |difference| < 2^COORD_BITS
  localparam int SUM_W  = 2 * MAG_W + 1;             // ax^2 + ay^2
  localparam int ACC_W  = 2 * MAG_W + 2 * UNIT_FRAC_BITS + 6;
  localparam int ROOT_W = UNIT_FRAC_BITS + 1;        // result magnitude <= 2^F
  localparam int LANE_LAT = UNIT_FRAC_BITS + 2;      // seed stage + one per digit

  localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * UNIT_W;

  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
  } side_t;

  // Residual E = rhs - Q^2*s and cross term G = Q*s with Q = 2r - 1.
  typedef struct packed {
    logic signed [ACC_W-1:0] e;
    logic signed [ACC_W-1:0] g;
    logic [ROOT_W-1:0]       r;
  } root_t;

  function automatic root_t root_step(root_t cur, logic [SUM_W-1:0] s, int b);
    logic signed [ACC_W-1:0] se;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] dif;
    root_t nxt;
    se   = $signed({{(ACC_W - SUM_W){1'b0}}, s});
    term = (cur.g <<< (b + 2)) + (se <<< (2 * b + 2));
    dif  = cur.e - term;
    nxt  = cur;
    if (!dif[ACC_W-1]) begin
      nxt.e = dif;
      nxt.g = cur.g + (se <<< (b + 1));
      nxt.r = cur.r | (ROOT_W'(1) << b);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/suv_lane.sv @@
// One component lane: seeds the residual, then resolves one result digit per
// register stage, most significant first. Depends on suv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module suv_lane (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [suv_pkg::SUM_W-1:0]   a_sq,
  input  wire logic [suv_pkg::SUM_W-1:0]   s,
  output logic      [suv_pkg::ROOT_W-1:0]  mag
);

  localparam int NSTG = suv_pkg::UNIT_FRAC_BITS + 2;

  suv_pkg::root_t          st_r [NSTG];
  logic [suv_pkg::SUM_W-1:0] s_r [NSTG];

  logic signed [suv_pkg::ACC_W-1:0] se;
  logic signed [suv_pkg::ACC_W-1:0] sq_e;
  suv_pkg::root_t                   seed;

  always_comb begin
    se     = $signed({{(suv_pkg::ACC_W - suv_pkg::SUM_W){1'b0}}, s});
    sq_e   = $signed({{(suv_pkg::ACC_W - suv_pkg::SUM_W){1'b0}}, a_sq});
    // r = 0 gives Q = -1: E = 4*a^2*4^F - s, G = -s
    seed.e = (sq_e <<< (2 * suv_pkg::UNIT_FRAC_BITS + 2)) - se;
    seed.g = -se;
    seed.r = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= seed;
      s_r[0]  <= s;
    end
  end

  for (genvar k = 0; k < NSTG - 1; k++) begin : g_digit
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= suv_pkg::root_step(st_r[k], s_r[k], suv_pkg::UNIT_FRAC_BITS - k);
        s_r[k+1]  <= s_r[k];
      end
    end
  end

  assign mag = st_r[NSTG-1].r;

endmodule

`default_nettype wire

@@ rtl/core/segment_unit_vector_top.sv @@
// Top level of the segment unit vector block: difference, squares, sum,
// two digit-recurrence lanes and the output register. Depends on suv_pkg, suv_lane.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   tdata                                     tuser
// in_*      in    start_x, start_y, end_x, end_y (24b each)  command
// out_*     out   unit_x, unit_y (16b each)                  zero_length
//
// Fully pipelined: one transfer per cycle in, one per cycle out, unless out_tready stalls.
// Registers in order: stage 1, squares, squared length, the lane stages of the
// one-digit-per-stage rounding recurrence (15 digits plus seed stage), output register.
// rst_n (synchronous, active low) clears only the valid bits.
// A stall on out_tready freezes the whole pipe; in_tready drops with it.
module segment_unit_vector_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // start_x [23:0], start_y [47:24], end_x [71:48], end_y [95:72]
  input  wire logic [suv_pkg::IN_TDATA_W-1:0]     in_tdata,
  // command [0]
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // unit_x [15:0], unit_y [31:16]
  output logic      [suv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // zero_length [0]
  output logic                                    out_tuser
);

  localparam int CB = suv_pkg::COORD_BITS;
  localparam int NS = 3 + suv_pkg::LANE_LAT;  // sideband stages up to lane output

  logic en;

  // ---- stage 1: differences, command select, magnitude ----
  logic signed [suv_pkg::DIFF_W-1:0] dx, dy, vx, vy, absx, absy;
  suv_pkg::side_t                    side_in;

  always_comb begin
    dx = $signed({in_tdata[3*CB-1], in_tdata[3*CB-1:2*CB]})
       - $signed({in_tdata[CB-1], in_tdata[CB-1:0]});
    dy = $signed({in_tdata[4*CB-1], in_tdata[4*CB-1:3*CB]})
       - $signed({in_tdata[2*CB-1], in_tdata[2*CB-1:CB]});
    if (in_tuser) begin
      vx = -dy;   // left normal
      vy = dx;
    end else begin
      vx = dx;
      vy = dy;
    end
    absx = vx[suv_pkg::DIFF_W-1] ? -vx : vx;
    absy = vy[suv_pkg::DIFF_W-1] ? -vy : vy;
    side_in.zero  = (vx == '0) && (vy == '0);
    side_in.neg_x = vx[suv_pkg::DIFF_W-1];
    side_in.neg_y = vy[suv_pkg::DIFF_W-1];
  end

  logic                          vld_r [NS];
  suv_pkg::side_t                side_r [NS];
  logic [suv_pkg::MAG_W-1:0]     ax1_r, ay1_r;
  logic [2*suv_pkg::MAG_W-1:0]   sqx2_r, sqy2_r;
  logic [suv_pkg::SUM_W-1:0]     sqx3_r, sqy3_r, s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < NS; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < NS; i++) begin
        side_r[i] <= side_r[i-1];
      end
      ax1_r  <= absx[suv_pkg::MAG_W-1:0];
      ay1_r  <= absy[suv_pkg::MAG_W-1:0];
      // ---- stage 2: squares ----
      sqx2_r <= ax1_r * ax1_r;
      sqy2_r <= ay1_r * ay1_r;
      // ---- stage 3: squared length ----
      sqx3_r <= {1'b0, sqx2_r};
      sqy3_r <= {1'b0, sqy2_r};
      s3_r   <= {1'b0, sqx2_r} + {1'b0, sqy2_r};
    end
  end

  // ---- rounding recurrence lanes ----
  logic [suv_pkg::ROOT_W-1:0] magx, magy;

  suv_lane u_lane_x (.clk(clk), .en(en), .a_sq(sqx3_r), .s(s3_r), .mag(magx));
  suv_lane u_lane_y (.clk(clk), .en(en), .a_sq(sqy3_r), .s(s3_r), .mag(magy));

  // ---- output register ----
  logic                        out_valid_r;
  logic [suv_pkg::UNIT_W-1:0]  ux_r, uy_r;
  logic                        zl_r;
  logic [suv_pkg::UNIT_W-1:0]  ux_nxt, uy_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    ux_nxt = suv_pkg::UNIT_W'(magx);
    uy_nxt = suv_pkg::UNIT_W'(magy);
    if (side_r[NS-1].neg_x) ux_nxt = -ux_nxt;
    if (side_r[NS-1].neg_y) uy_nxt = -uy_nxt;
    if (side_r[NS-1].zero) begin
      ux_nxt = '0;
      uy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      zl_r <= side_r[NS-1].zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {uy_r, ux_r};
  assign out_tuser  = zl_r;

endmodule

`default_nettype wire

@@ tb/sv/suv_checker.sv @@
// Checker for the segment unit vector block: watches both stream channels,
// predicts each unit vector exactly and compares. Depends on suv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module suv_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [suv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tuser,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [suv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                            out_tuser,
  output int                                   fail_count,
  output int                                   pending
);
  import suv_pkg::*;

  typedef struct packed {
    logic [UNIT_W-1:0] ux;
    logic [UNIT_W-1:0] uy;
    logic              zlen;
  } unit_vec_t;

  unit_vec_t unit_q[$];

  // Largest r <= 2^F with (2r-1)^2 * s <= (a * 2^(F+1))^2: round-half-away of a*2^F/sqrt(s).
  function automatic logic [UNIT_W-1:0] rounded_mag(logic [63:0] a, logic [127:0] s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [63:0]  r;
    logic [63:0]  t;
    rhs = (a << (UNIT_FRAC_BITS + 1)) * (a << (UNIT_FRAC_BITS + 1));
    r = 0;
    for (int b = UNIT_FRAC_BITS; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t <= (64'd1 << UNIT_FRAC_BITS)) begin
        lhs = 128'(2 * t - 1) * 128'(2 * t - 1) * s;
        if (lhs <= rhs) r = t;
      end
    end
    return r[UNIT_W-1:0];
  endfunction

  function automatic unit_vec_t predict_unit(logic [IN_TDATA_W-1:0] d, logic cmd);
    longint sx, sy, ex, ey, dx, dy, vx, vy;
    logic [63:0]  ax, ay;
    logic [127:0] s;
    unit_vec_t    u;
    sx = longint'($signed(d[COORD_BITS-1:0]));
    sy = longint'($signed(d[2*COORD_BITS-1:COORD_BITS]));
    ex = longint'($signed(d[3*COORD_BITS-1:2*COORD_BITS]));
    ey = longint'($signed(d[4*COORD_BITS-1:3*COORD_BITS]));
    dx = ex - sx;
    dy = ey - sy;
    vx = cmd ? -dy : dx;
    vy = cmd ? dx : dy;
    u = '0;
    if (vx == 0 && vy == 0) begin
      u.zlen = 1'b1;
      return u;
    end
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    s = 128'(ax) * ax + 128'(ay) * ay;
    u.ux = rounded_mag(ax, s);
    u.uy = rounded_mag(ay, s);
    if (vx < 0) u.ux = -u.ux;
    if (vy < 0) u.uy = -u.uy;
    return u;
  endfunction

  always @(posedge clk) begin
    unit_vec_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) unit_q.push_back(predict_unit(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (unit_q.size() == 0) begin
          $error("result transfer with no prediction waiting");
          errs++;
        end else begin
          want = unit_q.pop_front();
          if (out_tdata[UNIT_W-1:0] !== want.ux) begin
            $error("unit_x expected %0d actual %0d", $signed(want.ux),
                   $signed(out_tdata[UNIT_W-1:0]));
            errs++;
          end
          if (out_tdata[2*UNIT_W-1:UNIT_W] !== want.uy) begin
            $error("unit_y expected %0d actual %0d", $signed(want.uy),
                   $signed(out_tdata[2*UNIT_W-1:UNIT_W]));
            errs++;
          end
          if (out_tuser !== want.zlen) begin
            $error("zero_length expected %0b actual %0b", want.zlen, out_tuser);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= unit_q.size();
  end
endmodule

`default_nettype wire

@@ tb/sv/tb_segment_unit_vector_top.sv @@
// Testbench top for segment_unit_vector_top: drives segments with random
// gaps and back-pressure, verdict from suv_checker. Depends on suv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tb_segment_unit_vector_top;
  import suv_pkg::*;

  localparam int DIRECTION   = 0;   // command: unit direction end - start
  localparam int LEFT_NORMAL = 1;   // command: unit left normal
  localparam int RANDOM_ITEMS = 1150;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit calm_phase = 1'b0;   // no gaps and no stalls while set

  always #10 clk = ~clk;

  segment_unit_vector_top DUT (.*);

  suv_checker u_checker (.*);

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure: about 30 percent stalls outside the calm phase.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm_phase || ($urandom_range(99) >= 30);
  end

  // One transfer; random gap before it unless calm. Changes at falling edge.
  task automatic send_segment(logic cmd, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                              logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
    while (!calm_phase && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {ey, ex, sy, sx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_BITS'($urandom);                            // full range
      1: return COORD_BITS'($signed(9'($urandom)));               // near origin
      2: return $urandom_range(1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                  : {1'b1, {(COORD_BITS-1){1'b0}}};
      default: return COORD_BITS'($signed(16'($urandom)));
    endcase
  endfunction

  localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  initial begin
    logic [COORD_BITS-1:0] ax, ay, bx, by;
    logic cmd;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: both commands over coinciding points, axis-aligned,
    // full-range differences, diagonals and ties.
    for (int c = DIRECTION; c <= LEFT_NORMAL; c++) begin
      send_segment(1'(c), '0, '0, '0, '0);
      send_segment(1'(c), CMAX, CMIN, CMAX, CMIN);
      send_segment(1'(c), '0, '0, 24'd256, '0);
      send_segment(1'(c), '0, '0, '0, -24'sd1);
      send_segment(1'(c), CMIN, CMIN, CMAX, CMAX);
      send_segment(1'(c), CMAX, CMAX, CMIN, CMIN);
      send_segment(1'(c), CMIN, '0, CMAX, '0);
      send_segment(1'(c), '0, CMAX, '0, CMIN);
      send_segment(1'(c), '0, '0, 24'd3, 24'd4);
      send_segment(1'(c), 24'd1, 24'd1, '0, 24'd2);
      send_segment(1'(c), '0, '0, 24'd1, 24'd1);
    end

    // Random: gaps and stalls throughout, but for a calm stretch (items 300 to 449).
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm_phase = (i >= 300 && i < 450);
      ax = rand_coord(); ay = rand_coord();
      cmd = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: begin bx = ax; by = ay; end                 // coinciding
        1: begin bx = ax; by = rand_coord(); end       // vertical
        2: begin bx = rand_coord(); by = ay; end       // horizontal
        3: begin bx = ax + 24'($urandom_range(3)); by = ay - 24'($urandom_range(3)); end
        default: begin bx = rand_coord(); by = rand_coord(); end
      endcase
      send_segment(cmd, ax, ay, bx, by);
    end
    calm_phase = 1'b0;
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire

@@ segment_unit_vector_top.f @@
rtl/core/suv_pkg.sv
rtl/core/suv_lane.sv
rtl/core/segment_unit_vector_top.sv
tb/sv/suv_checker.sv
tb/sv/tb_segment_unit_vector_top.sv
